// ===== rtl/ckap_pkg.sv =====
// ckap_pkg: shared types, constants and arithmetic helpers for the color key
// to premultiplied alpha pipeline. No dependencies.
package ckap_pkg;

	localparam int STAGES = 10;

	// configuration register indexes
	localparam logic [3:0] CFG_KEY_RED    = 4'd0;
	localparam logic [3:0] CFG_KEY_GREEN  = 4'd1;
	localparam logic [3:0] CFG_KEY_BLUE   = 4'd2;
	localparam logic [3:0] CFG_BASE_ALPHA = 4'd3;

	localparam logic [7:0] RST_KEY_RED    = 8'd100;
	localparam logic [7:0] RST_KEY_GREEN  = 8'd149;
	localparam logic [7:0] RST_KEY_BLUE   = 8'd237;
	localparam logic [7:0] RST_BASE_ALPHA = 8'd170;

	// squared distance at or above this puts the pixel 255 or more from the key
	localparam logic [17:0] FAR_D2      = 18'd65025;
	localparam logic [15:0] KEY_SPAN    = 16'd65280;  // 255.0 in 8.8 fixed point
	localparam logic [23:0] ALPHA_BIAS  = 24'd32640;  // half of KEY_SPAN
	localparam logic [15:0] PREMUL_BIAS = 16'd127;
	localparam logic [15:0] RECIP_255   = 16'h8081;   // 2^23/255, rounded up

	typedef struct packed {
		logic [18:0] rem;
		logic [15:0] root;
	} sqrt_t;

	typedef struct packed {
		logic ld_a;
		logic ld_b;
	} stage_ld_t;

	// one digit of the restoring square root
	function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [1:0] pair);
		logic [18:0] shifted;
		logic [18:0] trial;
		sqrt_t r;
		shifted = {s.rem[16:0], pair};
		trial   = {1'b0, s.root, 2'b01};
		if (shifted >= trial) begin
			r.rem  = shifted - trial;
			r.root = {s.root[14:0], 1'b1};
		end else begin
			r.rem  = shifted;
			r.root = {s.root[14:0], 1'b0};
		end
		return r;
	endfunction

	// floor(v/255), exact for any 16-bit v; callers keep the quotient below 256
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [31:0] prod;
		prod = 32'(v) * 32'(RECIP_255);
		return prod[30:23];
	endfunction

endpackage

// ===== rtl/ckap_dist.sv =====
// ckap_dist: squared RGB distance from pixel to key, two pipeline stages.
// Depends on ckap_pkg.
module ckap_dist (
	input  logic               clk,
	input  ckap_pkg::stage_ld_t ld,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic [7:0]         key_red,
	input  logic [7:0]         key_green,
	input  logic [7:0]         key_blue,
	output logic [17:0]        d2_s2
);

	logic [7:0]  dr_s1, dg_s1, db_s1;
	logic [15:0] sq_r, sq_g, sq_b;

	always_ff @(posedge clk) begin
		if (ld.ld_a) begin
			dr_s1 <= (red >= key_red) ? red - key_red : key_red - red;
			dg_s1 <= (green >= key_green) ? green - key_green : key_green - green;
			db_s1 <= (blue >= key_blue) ? blue - key_blue : key_blue - blue;
		end
	end

	assign sq_r = 16'(dr_s1) * 16'(dr_s1);
	assign sq_g = 16'(dg_s1) * 16'(dg_s1);
	assign sq_b = 16'(db_s1) * 16'(db_s1);

	always_ff @(posedge clk) begin
		if (ld.ld_b) begin
			d2_s2 <= 18'(sq_r) + 18'(sq_g) + 18'(sq_b);
		end
	end

endmodule

// ===== rtl/ckap_sqrt_stage.sv =====
// ckap_sqrt_stage: four digits of the pipelined square root, one register.
// Depends on ckap_pkg.
module ckap_sqrt_stage (
	input  logic            clk,
	input  logic            ld,
	input  ckap_pkg::sqrt_t sq_in,
	input  logic [7:0]      pairs,
	output ckap_pkg::sqrt_t sq_out
);

	ckap_pkg::sqrt_t st [0:4];

	always_comb begin
		st[0] = sq_in;
		for (int i = 0; i < 4; i++) begin
			st[i+1] = ckap_pkg::sqrt_step(st[i], pairs[7-2*i -: 2]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			sq_out <= st[4];
		end
	end

endmodule

// ===== rtl/ckap_alpha.sv =====
// ckap_alpha: alpha = base * (1 - dist/255) rounded half up, or zero when kill
// is set, two stages. Depends on ckap_pkg.
module ckap_alpha (
	input  logic                clk,
	input  ckap_pkg::stage_ld_t ld,
	input  logic [15:0]         dist_fx,
	input  logic                kill,
	input  logic [7:0]          base,
	output logic [7:0]          alpha_s8
);

	logic [15:0] span_left;
	logic [23:0] prod;
	logic [15:0] y_s7;
	logic        kill_s7;

	assign span_left = ckap_pkg::KEY_SPAN - dist_fx;
	assign prod      = 24'(base) * 24'(span_left) + ckap_pkg::ALPHA_BIAS;

	// prod / 65280 is taken as (prod >> 8) / 255
	always_ff @(posedge clk) begin
		if (ld.ld_a) begin
			y_s7    <= prod[23:8];
			kill_s7 <= kill;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_b) begin
			alpha_s8 <= kill_s7 ? 8'd0 : ckap_pkg::div255(y_s7);
		end
	end

endmodule

// ===== rtl/ckap_premul.sv =====
// ckap_premul: premultiplies the three channels by alpha, two stages, and
// holds the output register. Depends on ckap_pkg.
module ckap_premul (
	input  logic                clk,
	input  ckap_pkg::stage_ld_t ld,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic [7:0]          alpha,
	output logic [7:0]          out_alpha,
	output logic [7:0]          out_red,
	output logic [7:0]          out_green,
	output logic [7:0]          out_blue
);

	logic [15:0] wr_s9, wg_s9, wb_s9;
	logic [7:0]  alpha_s9;
	logic [7:0]  alpha_s10, red_s10, green_s10, blue_s10;

	// (2ca+255)/510 equals (ca+127)/255 since the numerator is always odd
	always_ff @(posedge clk) begin
		if (ld.ld_a) begin
			wr_s9    <= 16'(red) * 16'(alpha) + ckap_pkg::PREMUL_BIAS;
			wg_s9    <= 16'(green) * 16'(alpha) + ckap_pkg::PREMUL_BIAS;
			wb_s9    <= 16'(blue) * 16'(alpha) + ckap_pkg::PREMUL_BIAS;
			alpha_s9 <= alpha;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_b) begin
			alpha_s10 <= alpha_s9;
			red_s10   <= ckap_pkg::div255(wr_s9);
			green_s10 <= ckap_pkg::div255(wg_s9);
			blue_s10  <= ckap_pkg::div255(wb_s9);
		end
	end

	assign out_alpha = alpha_s10;
	assign out_red   = red_s10;
	assign out_green = green_s10;
	assign out_blue  = blue_s10;

endmodule

// ===== rtl/color_key_alpha_premultiply_unit.sv =====
// Converts an RGB pixel stream into premultiplied ARGB keyed on a color.
// Top level; depends on ckap_pkg, ckap_dist, ckap_sqrt_stage, ckap_alpha,
// ckap_premul.
//
// One pixel in and one ARGB pixel out per clock while out_ready is high,
// through ten register stages: two stages of distance, four stages of a
// 16-digit square root at four digits each, two stages for alpha and two
// for premultiply. Each stage advances on its own, so bubbles close up and
// pixels keep entering while a result waits at the output, until every
// stage holds an item. Black pixels come out as all zeros; a pixel on the
// key gets base_alpha; other pixels fade linearly to zero alpha at RGB
// distance 255. Key and base alpha registers are written through the
// cfg channel (always ready) and should only change while the pipeline
// is empty.
module color_key_alpha_premultiply_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_alpha,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int NST = ckap_pkg::STAGES;

	logic [7:0] key_red_q, key_green_q, key_blue_q, base_alpha_q;

	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	logic [23:0] pix_s   [0:7];
	logic        black_s [0:5];
	logic        far_s   [2:5];
	logic [7:0]  lo_s3;

	logic [17:0]         d2_s2;
	ckap_pkg::sqrt_t     sq_s [0:3];
	logic [7:0]          alpha_s8;
	ckap_pkg::stage_ld_t dist_ld, alpha_ld, pm_ld;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_red_q    <= ckap_pkg::RST_KEY_RED;
			key_green_q  <= ckap_pkg::RST_KEY_GREEN;
			key_blue_q   <= ckap_pkg::RST_KEY_BLUE;
			base_alpha_q <= ckap_pkg::RST_BASE_ALPHA;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ckap_pkg::CFG_KEY_RED:    key_red_q    <= cfg_data;
				ckap_pkg::CFG_KEY_GREEN:  key_green_q  <= cfg_data;
				ckap_pkg::CFG_KEY_BLUE:   key_blue_q   <= cfg_data;
				ckap_pkg::CFG_BASE_ALPHA: base_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its contents move on
	always_comb begin
		en[NST-1] = !v_q[NST-1] || out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// pixel and flag lines that ride along with the arithmetic
	always_ff @(posedge clk) begin
		if (en[0]) begin
			pix_s[0]   <= {red, green, blue};
			black_s[0] <= (red == 8'd0) && (green == 8'd0) && (blue == 8'd0);
		end
		for (int k = 1; k < 8; k++) begin
			if (en[k]) begin
				pix_s[k] <= pix_s[k-1];
			end
		end
		for (int k = 1; k < 6; k++) begin
			if (en[k]) begin
				black_s[k] <= black_s[k-1];
			end
		end
		if (en[2]) begin
			far_s[2] <= (d2_s2 >= ckap_pkg::FAR_D2);
			lo_s3    <= d2_s2[7:0];
		end
		for (int k = 3; k < 6; k++) begin
			if (en[k]) begin
				far_s[k] <= far_s[k-1];
			end
		end
	end

	assign dist_ld  = '{ld_a: en[0], ld_b: en[1]};
	assign alpha_ld = '{ld_a: en[6], ld_b: en[7]};
	assign pm_ld    = '{ld_a: en[8], ld_b: en[9]};

	ckap_dist u_dist (
		.clk       (clk),
		.ld        (dist_ld),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.key_red   (key_red_q),
		.key_green (key_green_q),
		.key_blue  (key_blue_q),
		.d2_s2     (d2_s2)
	);

	// radicand is d2 << 16; only d2 below 65025 matters, so 16 bits of it
	generate
		for (genvar k = 0; k < 4; k++) begin : g_sqrt
			ckap_pkg::sqrt_t sq_in;
			logic [7:0]      pairs;
			if (k == 0) begin : g_first
				assign sq_in = '0;
				assign pairs = d2_s2[15:8];
			end else if (k == 1) begin : g_second
				assign sq_in = sq_s[k-1];
				assign pairs = lo_s3;
			end else begin : g_rest
				assign sq_in = sq_s[k-1];
				assign pairs = 8'h00;
			end
			ckap_sqrt_stage u_stage (
				.clk    (clk),
				.ld     (en[k+2]),
				.sq_in  (sq_in),
				.pairs  (pairs),
				.sq_out (sq_s[k])
			);
		end
	endgenerate

	ckap_alpha u_alpha (
		.clk      (clk),
		.ld       (alpha_ld),
		.dist_fx  (sq_s[3].root),
		.kill     (black_s[5] || far_s[5]),
		.base     (base_alpha_q),
		.alpha_s8 (alpha_s8)
	);

	ckap_premul u_premul (
		.clk       (clk),
		.ld        (pm_ld),
		.red       (pix_s[7][23:16]),
		.green     (pix_s[7][15:8]),
		.blue      (pix_s[7][7:0]),
		.alpha     (alpha_s8),
		.out_alpha (out_alpha),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue)
	);

`ifndef SYNTHESIS
	a_empty_takes_item: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline holds no result but refuses an item");

	a_zero_alpha_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_alpha == 8'd0 |->
			out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
		else $error("zero alpha with nonzero color channel");

	a_root_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[5] && !far_s[5] |-> sq_s[3].root < ckap_pkg::KEY_SPAN)
		else $error("distance reaches key span on a near pixel");
`endif

endmodule
